// ----- design/dlsq_pkg.sv -----
// Shared types, codes and constants of the delta-list sleep queue.
`default_nettype none

package dlsq_pkg;

   // Payload widths
   localparam int OP_W   = 2;
   localparam int ID_W   = 4;
   localparam int DATA_W = 32;
   localparam int KIND_W = 2;

   // Parameter defaults
   localparam int SLOTS_DEF       = 16;
   localparam int MS_PER_TICK_DEF = 10;

   // Most wake transactions one tick may produce
   localparam int MAX_WAKE = 16;

   // Request operations
   localparam logic [OP_W-1:0] OP_SLEEP  = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_WAKE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

   // One queue entry: process id and delta to the previous deadline
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [DATA_W-1:0] delta;
   } entry_type;

   // Shared arithmetic unit
   typedef enum logic [1:0] {
      ALU_SUB,
      ALU_ADD_SAT,
      ALU_MUL
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } alu_req_type;

   // res carries the low word, hi the upper word of a product
   typedef struct packed {
      logic [DATA_W-1:0] res;
      logic [DATA_W-1:0] hi;
      logic              borrow;
   } alu_rsp_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL_BACK,
      ST_REM,
      ST_ROUND,
      ST_SCAN,
      ST_SHIFT_PREP,
      ST_SHIFT,
      ST_INSERT,
      ST_TICK_HEAD,
      ST_WAKE,
      ST_COMPACT,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ----- design/dlsq_req_if.sv -----
// Request channel of the sleep queue: operation, process id, sleep length.
`default_nettype none

interface dlsq_req_if;
   logic                        valid;
   logic                        ready;
   logic [dlsq_pkg::OP_W-1:0]   op;
   logic [dlsq_pkg::ID_W-1:0]   proc_id;
   logic [dlsq_pkg::DATA_W-1:0] sleep_ms;

   modport source (output valid, output op, output proc_id, output sleep_ms, input ready);
   modport sink   (input valid, input op, input proc_id, input sleep_ms, output ready);
endinterface

`default_nettype wire

// ----- design/dlsq_rsp_if.sv -----
// Result channel of the sleep queue: kind, id, remaining ticks, last marker.
`default_nettype none

interface dlsq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dlsq_pkg::KIND_W-1:0] kind;
   logic [dlsq_pkg::ID_W-1:0]   out_id;
   logic [dlsq_pkg::DATA_W-1:0] remaining_ticks;
   logic                        last;

   modport source (output valid, output kind, output out_id, output remaining_ticks,
                   output last, input ready);
   modport sink   (input valid, input kind, input out_id, input remaining_ticks,
                   input last, output ready);
endinterface

`default_nettype wire

// ----- design/delta_list_sleep_queue.sv -----
// Top level of the delta-list sleep queue: sequencer, entry store and shared unit.
//
//   channel   dir  handshake          payload
//   req_if    in   valid/ready        op, proc_id, sleep_ms
//   rsp_if    out  valid/ready        kind, out_id, remaining_ticks, last
//
// One transaction at a time; req_if.ready is high only while the sequencer is idle.
// Sleep: multiply by the reciprocal of MS_PER_TICK, multiply back, take the remainder, round,
//   scan the queue, read the tail, shift entries up from the tail to the insert point, insert;
//   a full queue goes straight to an error and an empty one skips the scan and the shift.
// Tick: decrement the head, or emit a wake per expired id and move the entries behind them down.
// Remove: scan to the id, move the entries behind it down, then emit the result.
// All arithmetic goes through the one shared subtract/add/multiply unit and every entry access
// through the store's single write port and single read port. Synchronous reset empties the
// queue; no clearing pass. A stalled rsp_if holds the sequencer in place.
`default_nettype none

module delta_list_sleep_queue #(
   parameter int SLOTS       = dlsq_pkg::SLOTS_DEF,
   parameter int MS_PER_TICK = dlsq_pkg::MS_PER_TICK_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dlsq_req_if.sink   req_if,
   dlsq_rsp_if.source rsp_if
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int LEN_W = $clog2(SLOTS + 1);
   localparam int REM_W = $clog2(2 * MS_PER_TICK);
   localparam int DW    = dlsq_pkg::DATA_W;
   // Reciprocal below 2^DW; the quotient it gives is exact or one short
   localparam int             RECIP_SH = DW - 1 + $clog2(MS_PER_TICK);
   localparam logic [DW-1:0]  RECIP    = DW'((64'd1 << RECIP_SH) / 64'(MS_PER_TICK));

   // Control registers
   dlsq_pkg::state_type state_ff, state_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [dlsq_pkg::OP_W-1:0]   op_ff, op_in;
   logic [dlsq_pkg::ID_W-1:0]   id_ff, id_in;
   logic [DW-1:0]               div_ff, div_in;
   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [DW-1:0]               acc_ff, acc_in;
   logic [DW-1:0]               dpos_ff, dpos_in;
   logic [LEN_W-1:0]            pos_ff, pos_in;
   logic                        posset_ff, posset_in;
   logic [LEN_W-1:0]            idx_ff, idx_in;
   logic [LEN_W-1:0]            k_ff, k_in;
   logic                        adj_ff, adj_in;
   logic [dlsq_pkg::ID_W-1:0]   wake_id_ff, wake_id_in;
   logic [dlsq_pkg::KIND_W-1:0] res_kind_ff, res_kind_in;

   // Result register
   logic [dlsq_pkg::KIND_W-1:0] rsp_kind_ff;
   logic [dlsq_pkg::ID_W-1:0]   rsp_id_ff;
   logic [DW-1:0]               rsp_rem_ff;
   logic                        rsp_last_ff;
   logic                        rsp_load;
   logic [dlsq_pkg::KIND_W-1:0] ld_kind;
   logic [dlsq_pkg::ID_W-1:0]   ld_id;
   logic [DW-1:0]               ld_rem;
   logic                        ld_last;

   // Store and shared unit
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   dlsq_pkg::entry_type   wr_data;
   logic [IDX_W-1:0]      rd_addr;
   dlsq_pkg::entry_type   rd_data;
   dlsq_pkg::alu_req_type alu_req;
   dlsq_pkg::alu_rsp_type alu_rsp;

   // Helpers
   logic             accept;
   logic             out_free;
   logic [LEN_W-1:0] len_m1;
   logic [LEN_W-1:0] idx_p1;
   logic [LEN_W-1:0] idx_m1;
   logic [LEN_W-1:0] idx_m2;
   logic [LEN_W-1:0] dst_idx;
   logic             last_entry;
   logic             id_match;
   logic [2*DW-1:0]  prod;
   logic [2*DW-1:0]  prod_sh;
   logic [1:0]       round_inc;
   logic             wake_more;

   dlsq_mem #(
      .DEPTH (SLOTS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dlsq_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_if.ready = (state_ff == dlsq_pkg::ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign len_m1       = len_ff - LEN_W'(1);
   assign idx_p1       = idx_ff + LEN_W'(1);
   assign idx_m1       = idx_ff - LEN_W'(1);
   assign idx_m2       = idx_ff - LEN_W'(2);
   assign dst_idx      = idx_ff - k_ff;
   assign last_entry   = (idx_ff == len_m1);
   assign id_match     = (rd_data.id == id_ff);
   assign prod         = {alu_rsp.hi, alu_rsp.res};
   assign prod_sh      = prod >> RECIP_SH;
   assign wake_more    = (idx_ff < len_ff) && (rd_data.delta == '0) &&
                         (32'(idx_ff) < 32'(dlsq_pkg::MAX_WAKE));

   // Rounding step from the remainder, which may hold one extra divisor
   assign round_inc = (rem_ff == '0)                     ? {1'b0, div_ff == '0} :
                      (rem_ff > REM_W'(MS_PER_TICK))     ? 2'd2 : 2'd1;

   // Sequencer: next state, store access, shared unit operands
   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      op_in       = op_ff;
      id_in       = id_ff;
      div_in      = div_ff;
      rem_in      = rem_ff;
      acc_in      = acc_ff;
      dpos_in     = dpos_ff;
      pos_in      = pos_ff;
      posset_in   = posset_ff;
      idx_in      = idx_ff;
      k_in        = k_ff;
      adj_in      = adj_ff;
      wake_id_in  = wake_id_ff;
      res_kind_in = res_kind_ff;
      rsp_load    = 1'b0;
      ld_kind     = dlsq_pkg::KIND_WAKE;
      ld_id       = wake_id_ff;
      ld_rem      = '0;
      ld_last     = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = rd_data;
      rd_addr     = '0;
      alu_req     = '{op: dlsq_pkg::ALU_SUB, a: '0, b: '0};

      unique case (state_ff)
         dlsq_pkg::ST_IDLE: begin
            // Take a transaction; entry 0 is read meanwhile
            if (accept) begin
               op_in = req_if.op;
               id_in = req_if.proc_id;
               case (req_if.op)
                  dlsq_pkg::OP_SLEEP: begin
                     if (len_ff == LEN_W'(SLOTS)) begin
                        res_kind_in = dlsq_pkg::KIND_ERROR;
                        state_in    = dlsq_pkg::ST_EMIT;
                     end else begin
                        acc_in   = req_if.sleep_ms;
                        state_in = dlsq_pkg::ST_DIV;
                     end
                  end
                  dlsq_pkg::OP_TICK: begin
                     if (len_ff != '0) begin
                        state_in = dlsq_pkg::ST_TICK_HEAD;
                     end
                  end
                  dlsq_pkg::OP_REMOVE: begin
                     if (len_ff == '0) begin
                        res_kind_in = dlsq_pkg::KIND_ERROR;
                        state_in    = dlsq_pkg::ST_EMIT;
                     end else begin
                        idx_in   = '0;
                        acc_in   = '0;
                        state_in = dlsq_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = dlsq_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         dlsq_pkg::ST_DIV: begin
            // Estimate ms / MS_PER_TICK by the reciprocal
            alu_req.op = dlsq_pkg::ALU_MUL;
            alu_req.a  = acc_ff;
            alu_req.b  = RECIP;
            div_in     = prod_sh[DW-1:0];
            state_in   = dlsq_pkg::ST_MUL_BACK;
         end

         dlsq_pkg::ST_MUL_BACK: begin
            // Multiply the estimate back by the divisor
            alu_req.op = dlsq_pkg::ALU_MUL;
            alu_req.a  = div_ff;
            alu_req.b  = DW'(MS_PER_TICK);
            dpos_in    = alu_rsp.res;
            state_in   = dlsq_pkg::ST_REM;
         end

         dlsq_pkg::ST_REM: begin
            // Remainder of the estimate, below twice the divisor
            alu_req.op = dlsq_pkg::ALU_SUB;
            alu_req.a  = acc_ff;
            alu_req.b  = dpos_ff;
            rem_in     = alu_rsp.res[REM_W-1:0];
            state_in   = dlsq_pkg::ST_ROUND;
         end

         dlsq_pkg::ST_ROUND: begin
            // Correct the estimate, round up, at least one tick
            alu_req.op = dlsq_pkg::ALU_ADD_SAT;
            alu_req.a  = div_ff;
            alu_req.b  = DW'(round_inc);
            acc_in     = alu_rsp.res;
            idx_in     = '0;
            posset_in  = 1'b0;
            pos_in     = len_ff;
            state_in   = (len_ff == '0) ? dlsq_pkg::ST_INSERT : dlsq_pkg::ST_SCAN;
         end

         dlsq_pkg::ST_SCAN: begin
            // Walk entries in order, prefetch the next one
            rd_addr = idx_p1[IDX_W-1:0];
            if (op_ff == dlsq_pkg::OP_SLEEP) begin
               alu_req.op = dlsq_pkg::ALU_SUB;
               alu_req.a  = acc_ff;
               alu_req.b  = rd_data.delta;
               if (id_match) begin
                  res_kind_in = dlsq_pkg::KIND_ERROR;
                  state_in    = dlsq_pkg::ST_EMIT;
               end else begin
                  if (!posset_ff) begin
                     if (alu_rsp.borrow) begin
                        posset_in = 1'b1;
                        pos_in    = idx_ff;
                     end else begin
                        acc_in = alu_rsp.res;
                     end
                  end
                  if (last_entry) begin
                     state_in = dlsq_pkg::ST_SHIFT_PREP;
                  end else begin
                     idx_in = idx_p1;
                  end
               end
            end else begin
               alu_req.op = dlsq_pkg::ALU_ADD_SAT;
               alu_req.a  = acc_ff;
               alu_req.b  = rd_data.delta;
               acc_in     = alu_rsp.res;
               if (id_match) begin
                  dpos_in     = rd_data.delta;
                  pos_in      = idx_ff;
                  res_kind_in = dlsq_pkg::KIND_REMOVED;
                  if (last_entry) begin
                     len_in   = len_m1;
                     state_in = dlsq_pkg::ST_EMIT;
                  end else begin
                     idx_in   = idx_p1;
                     k_in     = LEN_W'(1);
                     adj_in   = 1'b1;
                     state_in = dlsq_pkg::ST_COMPACT;
                  end
               end else if (last_entry) begin
                  res_kind_in = dlsq_pkg::KIND_ERROR;
                  state_in    = dlsq_pkg::ST_EMIT;
               end else begin
                  idx_in = idx_p1;
               end
            end
         end

         dlsq_pkg::ST_SHIFT_PREP: begin
            // Read the tail entry before moving entries up
            rd_addr  = len_m1[IDX_W-1:0];
            idx_in   = len_ff;
            state_in = (pos_ff == len_ff) ? dlsq_pkg::ST_INSERT : dlsq_pkg::ST_SHIFT;
         end

         dlsq_pkg::ST_SHIFT: begin
            // Move entry idx-1 to idx; the entry at the insert point loses the new delta
            rd_addr    = idx_m2[IDX_W-1:0];
            alu_req.op = dlsq_pkg::ALU_SUB;
            alu_req.a  = rd_data.delta;
            alu_req.b  = acc_ff;
            wr_en      = 1'b1;
            wr_addr    = idx_ff[IDX_W-1:0];
            wr_data.id = rd_data.id;
            if (idx_m1 == pos_ff) begin
               wr_data.delta = alu_rsp.res;
               state_in      = dlsq_pkg::ST_INSERT;
            end else begin
               wr_data.delta = rd_data.delta;
               idx_in        = idx_m1;
            end
         end

         dlsq_pkg::ST_INSERT: begin
            // Place the sleeper
            wr_en         = 1'b1;
            wr_addr       = pos_ff[IDX_W-1:0];
            wr_data.id    = id_ff;
            wr_data.delta = acc_ff;
            len_in        = len_ff + LEN_W'(1);
            state_in      = dlsq_pkg::ST_IDLE;
         end

         dlsq_pkg::ST_TICK_HEAD: begin
            // Decrement the head, stopping at zero
            rd_addr    = IDX_W'(1);
            alu_req.op = dlsq_pkg::ALU_SUB;
            alu_req.a  = rd_data.delta;
            alu_req.b  = DW'(1);
            if ((rd_data.delta > DW'(1))) begin
               wr_en         = 1'b1;
               wr_addr       = '0;
               wr_data.id    = rd_data.id;
               wr_data.delta = alu_rsp.res;
               state_in      = dlsq_pkg::ST_IDLE;
            end else begin
               wake_id_in = rd_data.id;
               idx_in     = LEN_W'(1);
               state_in   = dlsq_pkg::ST_WAKE;
            end
         end

         dlsq_pkg::ST_WAKE: begin
            // Emit the pending id; the entry in rd_data tells whether another follows
            rd_addr = idx_ff[IDX_W-1:0];
            if (out_free) begin
               rsp_load = 1'b1;
               ld_kind  = dlsq_pkg::KIND_WAKE;
               ld_id    = wake_id_ff;
               ld_rem   = '0;
               ld_last  = !wake_more;
               if (wake_more) begin
                  rd_addr    = idx_p1[IDX_W-1:0];
                  wake_id_in = rd_data.id;
                  idx_in     = idx_p1;
               end else begin
                  k_in = idx_ff;
                  if (idx_ff == len_ff) begin
                     len_in   = '0;
                     state_in = dlsq_pkg::ST_IDLE;
                  end else begin
                     adj_in   = 1'b0;
                     state_in = dlsq_pkg::ST_COMPACT;
                  end
               end
            end
         end

         dlsq_pkg::ST_COMPACT: begin
            // Move entry idx down by k; after a removal the first one takes the gap's delta
            rd_addr       = idx_p1[IDX_W-1:0];
            alu_req.op    = dlsq_pkg::ALU_ADD_SAT;
            alu_req.a     = rd_data.delta;
            alu_req.b     = dpos_ff;
            wr_en         = 1'b1;
            wr_addr       = dst_idx[IDX_W-1:0];
            wr_data.id    = rd_data.id;
            wr_data.delta = adj_ff ? alu_rsp.res : rd_data.delta;
            adj_in        = 1'b0;
            if (last_entry) begin
               len_in   = len_ff - k_ff;
               state_in = (op_ff == dlsq_pkg::OP_REMOVE) ? dlsq_pkg::ST_EMIT
                                                         : dlsq_pkg::ST_IDLE;
            end else begin
               idx_in = idx_p1;
            end
         end

         dlsq_pkg::ST_EMIT: begin
            // Single closing transaction: removal or error
            if (out_free) begin
               rsp_load = 1'b1;
               ld_kind  = res_kind_ff;
               ld_id    = id_ff;
               ld_rem   = (res_kind_ff == dlsq_pkg::KIND_REMOVED) ? acc_ff : '0;
               ld_last  = 1'b1;
               state_in = dlsq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = dlsq_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlsq_pkg::ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      acc_ff      <= acc_in;
      dpos_ff     <= dpos_in;
      pos_ff      <= pos_in;
      posset_ff   <= posset_in;
      idx_ff      <= idx_in;
      k_ff        <= k_in;
      adj_ff      <= adj_in;
      wake_id_ff  <= wake_id_in;
      res_kind_ff <= res_kind_in;
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_kind_ff <= ld_kind;
         rsp_id_ff   <= ld_id;
         rsp_rem_ff  <= ld_rem;
         rsp_last_ff <= ld_last;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.kind            = rsp_kind_ff;
   assign rsp_if.out_id          = rsp_id_ff;
   assign rsp_if.remaining_ticks = rsp_rem_ff;
   assign rsp_if.last            = rsp_last_ff;

endmodule

`default_nettype wire

// ----- design/dlsq_alu.sv -----
// Shared 32-bit subtract, saturating add and multiply unit used by the arithmetic steps of the sequencer.
`default_nettype none

module dlsq_alu (
   input  dlsq_pkg::alu_req_type alu_req,
   output dlsq_pkg::alu_rsp_type alu_rsp
);

   logic [dlsq_pkg::DATA_W:0]     diff;
   logic [dlsq_pkg::DATA_W:0]     sum;
   logic [2*dlsq_pkg::DATA_W-1:0] prod;

   assign diff = {1'b0, alu_req.a} - {1'b0, alu_req.b};
   assign sum  = {1'b0, alu_req.a} + {1'b0, alu_req.b};
   assign prod = {{dlsq_pkg::DATA_W{1'b0}}, alu_req.a} *
                 {{dlsq_pkg::DATA_W{1'b0}}, alu_req.b};

   // Select subtract with borrow, add clamped at all ones, or full product
   always_comb begin
      alu_rsp.res    = '0;
      alu_rsp.hi     = '0;
      alu_rsp.borrow = 1'b0;
      unique case (alu_req.op)
         dlsq_pkg::ALU_SUB: begin
            alu_rsp.res    = diff[dlsq_pkg::DATA_W-1:0];
            alu_rsp.borrow = diff[dlsq_pkg::DATA_W];
         end
         dlsq_pkg::ALU_ADD_SAT: begin
            alu_rsp.res = sum[dlsq_pkg::DATA_W] ? '1 : sum[dlsq_pkg::DATA_W-1:0];
         end
         dlsq_pkg::ALU_MUL: begin
            alu_rsp.res = prod[dlsq_pkg::DATA_W-1:0];
            alu_rsp.hi  = prod[2*dlsq_pkg::DATA_W-1:dlsq_pkg::DATA_W];
         end
         default: begin
            alu_rsp.res = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- design/dlsq_mem.sv -----
// Entry store of the sleep queue: one write port, one registered read port.
`default_nettype none

module dlsq_mem #(
   parameter  int DEPTH  = dlsq_pkg::SLOTS_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  dlsq_pkg::entry_type wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output dlsq_pkg::entry_type rd_data
);

   dlsq_pkg::entry_type store_ff [DEPTH];
   dlsq_pkg::entry_type rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read one entry, data shows the cycle after
   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sim/dlsq_result_checker.sv -----
// Checker of the sleep queue: predicts wake, removal and error results and compares them.
`timescale 1ns / 100ps

module dlsq_result_checker #(
   parameter int SLOTS       = dlsq_pkg::SLOTS_DEF,
   parameter int MS_PER_TICK = dlsq_pkg::MS_PER_TICK_DEF
) (
   input  logic clock,
   input  logic reset,
   dlsq_req_if  req_mon,
   dlsq_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [dlsq_pkg::KIND_W-1:0] kind;
      logic [dlsq_pkg::ID_W-1:0]   out_id;
      logic [dlsq_pkg::DATA_W-1:0] ticks;
      logic                        last;
   } queue_result_type;

   // Shadow copy of the delta list
   logic [dlsq_pkg::ID_W-1:0]   sleeper_id    [SLOTS];
   logic [dlsq_pkg::DATA_W-1:0] sleeper_delta [SLOTS];
   int                          sleeper_count;

   queue_result_type expected_results [$];
   int               mismatches;

   initial begin
      sleeper_count = 0;
      mismatches    = 0;
   end

   function automatic int find_sleeper(input logic [dlsq_pkg::ID_W-1:0] id);
      for (int i = 0; i < sleeper_count; i++) begin
         if (sleeper_id[i] == id) return i;
      end
      return -1;
   endfunction

   function automatic void post_result(input logic [dlsq_pkg::KIND_W-1:0] kind,
                                       input logic [dlsq_pkg::ID_W-1:0] id,
                                       input logic [dlsq_pkg::DATA_W-1:0] ticks,
                                       input logic last);
      queue_result_type r;
      r.kind   = kind;
      r.out_id = id;
      r.ticks  = ticks;
      r.last   = last;
      expected_results.push_back(r);
   endfunction

   // Advance the shadow list by one request and queue the results it causes
   task automatic predict_request(input logic [dlsq_pkg::OP_W-1:0] op,
                                  input logic [dlsq_pkg::ID_W-1:0] id,
                                  input logic [dlsq_pkg::DATA_W-1:0] ms);
      logic [dlsq_pkg::DATA_W-1:0] t;
      logic [63:0]                 sum;
      logic [63:0]                 nd;
      int                          i;
      int                          pos;
      int                          woken;
      case (op)
         dlsq_pkg::OP_SLEEP: begin
            if (find_sleeper(id) >= 0 || sleeper_count >= SLOTS) begin
               post_result(dlsq_pkg::KIND_ERROR, id, '0, 1'b1);
            end else begin
               // Round up to whole ticks, at least one
               t = ms / dlsq_pkg::DATA_W'(MS_PER_TICK);
               if (ms % dlsq_pkg::DATA_W'(MS_PER_TICK) != 0) t = t + 1;
               if (t == 0) t = 1;
               // Walk past every deadline earlier or equal
               i = 0;
               while (i < sleeper_count) begin
                  if (t < sleeper_delta[i]) begin
                     sleeper_delta[i] = sleeper_delta[i] - t;
                     break;
                  end
                  t = t - sleeper_delta[i];
                  i++;
               end
               for (int j = sleeper_count; j > i; j--) begin
                  sleeper_id[j]    = sleeper_id[j-1];
                  sleeper_delta[j] = sleeper_delta[j-1];
               end
               sleeper_id[i]    = id;
               sleeper_delta[i] = t;
               sleeper_count++;
            end
         end
         dlsq_pkg::OP_TICK: begin
            if (sleeper_count > 0) begin
               if (sleeper_delta[0] > 0) sleeper_delta[0] = sleeper_delta[0] - 1;
               woken = 0;
               while (sleeper_count > 0 && sleeper_delta[0] == 0 &&
                      woken < dlsq_pkg::MAX_WAKE) begin
                  post_result(dlsq_pkg::KIND_WAKE, sleeper_id[0], '0, 1'b0);
                  woken++;
                  for (int j = 1; j < sleeper_count; j++) begin
                     sleeper_id[j-1]    = sleeper_id[j];
                     sleeper_delta[j-1] = sleeper_delta[j];
                  end
                  sleeper_count--;
               end
               if (woken > 0) expected_results[expected_results.size()-1].last = 1'b1;
            end
         end
         dlsq_pkg::OP_REMOVE: begin
            pos = find_sleeper(id);
            if (pos < 0) begin
               post_result(dlsq_pkg::KIND_ERROR, id, '0, 1'b1);
            end else begin
               sum = '0;
               for (int j = 0; j <= pos; j++) sum = sum + 64'(sleeper_delta[j]);
               if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
               // Fold the removed delta into the follower, saturating
               if (pos + 1 < sleeper_count) begin
                  nd = 64'(sleeper_delta[pos+1]) + 64'(sleeper_delta[pos]);
                  sleeper_delta[pos+1] = (nd > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nd[31:0];
               end
               for (int j = pos + 1; j < sleeper_count; j++) begin
                  sleeper_id[j-1]    = sleeper_id[j];
                  sleeper_delta[j-1] = sleeper_delta[j];
               end
               sleeper_count--;
               post_result(dlsq_pkg::KIND_REMOVED, id, sum[31:0], 1'b1);
            end
         end
         default: begin
         end
      endcase
   endtask

   // Compare each result transaction, then predict from each request transaction
   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         sleeper_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected result kind %0d id %0d ticks %0d last %0d",
                           $realtime, rsp_mon.kind, rsp_mon.out_id,
                           rsp_mon.remaining_ticks, rsp_mon.last);
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.kind !== want.kind || rsp_mon.out_id !== want.out_id ||
                   rsp_mon.remaining_ticks !== want.ticks || rsp_mon.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"%0t: result mismatch, expected kind %0d id %0d ticks %0d ",
                               "last %0d, got kind %0d id %0d ticks %0d last %0d"},
                              $realtime, want.kind, want.out_id, want.ticks, want.last,
                              rsp_mon.kind, rsp_mon.out_id, rsp_mon.remaining_ticks,
                              rsp_mon.last);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_request(req_mon.op, req_mon.proc_id, req_mon.sleep_ms);
      end
      fail_count    <= mismatches;
      pending_count <= expected_results.size();
   end

endmodule

// ----- sim/delta_list_sleep_queue_tb.sv -----
// Testbench top of the sleep queue: clock, reset, request and result stimulus, verdict.
`timescale 1ns / 100ps

module delta_list_sleep_queue_tb;

   localparam logic [dlsq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 120;
   localparam int MAX_GAP      = 16;

   logic clock;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;

   int   sender_idle_pct    = 0;
   int   receiver_stall_pct = 0;
   bit   pressure_on        = 1'b0;

   // Ids recently put to sleep, to aim removals at queued entries
   logic [dlsq_pkg::ID_W-1:0] slept_ids [$];

   dlsq_req_if req_ch ();
   dlsq_rsp_if rsp_ch ();

   delta_list_sleep_queue DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   dlsq_result_checker u_result_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Drive result ready; hold off once for a long stretch under pressure
   initial begin
      int hold_count;
      hold_count   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_on && hold_count < HOLD_CYCLES) begin
            hold_count++;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Offer one request transaction after a random gap; return at a falling edge
   task automatic send_request(input logic [dlsq_pkg::OP_W-1:0] op,
                               input logic [dlsq_pkg::ID_W-1:0] id,
                               input logic [dlsq_pkg::DATA_W-1:0] ms);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.op       <= op;
      req_ch.proc_id  <= id;
      req_ch.sleep_ms <= ms;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct = sender_pct;
      receiver_stall_pct <= receiver_pct;
   endtask

   // Mostly short sleeps and ticks, some removals of queued ids, a little noise
   task automatic run_random_phase(input int items);
      int                          count;
      int                          pick;
      logic [dlsq_pkg::OP_W-1:0]   op;
      logic [dlsq_pkg::ID_W-1:0]   id;
      logic [dlsq_pkg::DATA_W-1:0] ms;
      count = 0;
      while (count < items) begin
         pick = $urandom_range(99);
         id   = $urandom_range(15);
         ms   = $urandom;
         if (pick < 45) begin
            op = dlsq_pkg::OP_SLEEP;
            if ($urandom_range(9) != 0) ms = $urandom_range(80);
            slept_ids.push_back(id);
            if (slept_ids.size() > 8) void'(slept_ids.pop_front());
         end else if (pick < 80) begin
            op = dlsq_pkg::OP_TICK;
         end else if (pick < 96) begin
            op = dlsq_pkg::OP_REMOVE;
            if (slept_ids.size() > 0 && $urandom_range(3) != 0)
               id = slept_ids[$urandom_range(slept_ids.size() - 1)];
         end else begin
            op = OP_UNUSED;
         end
         send_request(op, id, ms);
         if (op != OP_UNUSED) count++;
      end
   endtask

   initial begin
      req_ch.valid    = 1'b0;
      req_ch.op       = dlsq_pkg::OP_SLEEP;
      req_ch.proc_id  = '0;
      req_ch.sleep_ms = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty tick, absent removal, zero and longest sleeps, unused op
      send_request(dlsq_pkg::OP_TICK, 4'hA, 32'hFFFF_FFFF);
      send_request(dlsq_pkg::OP_REMOVE, 4'd3, 32'd0);
      send_request(dlsq_pkg::OP_SLEEP, 4'd0, 32'd0);
      send_request(dlsq_pkg::OP_SLEEP, 4'd15, 32'hFFFF_FFFF);
      send_request(dlsq_pkg::OP_SLEEP, 4'd9, 32'd19);
      send_request(OP_UNUSED, 4'd6, 32'h5555_AAAA);
      send_request(dlsq_pkg::OP_REMOVE, 4'd15, 32'd0);
      send_request(dlsq_pkg::OP_REMOVE, 4'd0, 32'd0);
      send_request(dlsq_pkg::OP_TICK, 4'd5, 32'd0);
      send_request(dlsq_pkg::OP_TICK, 4'd0, 32'd0);

      // Fill every slot with equal deadlines, overflow it, then wake all at once
      for (int i = 0; i < 16; i++)
         send_request(dlsq_pkg::OP_SLEEP, dlsq_pkg::ID_W'(i),
                      dlsq_pkg::DATA_W'(11 + i % 10));
      send_request(dlsq_pkg::OP_SLEEP, 4'd4, 32'd0);
      send_request(dlsq_pkg::OP_TICK, 4'd0, 32'd0);
      send_request(dlsq_pkg::OP_TICK, 4'hF, 32'h0F0F_F0F0);

      // Random phases across idling patterns
      run_random_phase(20);
      set_idling(45, 0);
      run_random_phase(20);

      // Stall the result side for long while requests keep coming
      set_idling(0, 0);
      pressure_on <= 1'b1;
      run_random_phase(15);

      set_idling(0, 45);
      run_random_phase(20);
      set_idling(26, 26);
      run_random_phase(20);
      set_idling(0, 0);
      req_ch.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("delta_list_sleep_queue test passed");
      end else begin
         $display("delta_list_sleep_queue test failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("delta_list_sleep_queue test failed");
      $finish;
   end

endmodule
